### rtl/core/ufme_pkg.sv
`default_nettype none

package ufme_pkg;

  // Table geometry
  localparam int NODES   = 1024;
  localparam int IDX_W   = $clog2(NODES);
  localparam int ENTRY_W = IDX_W + 2;
  localparam int FIELD_W = 10;
  localparam int SIZE_W  = 11;
  localparam int CNT_W   = 10;

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;

  // Input transfer: two node indexes
  typedef struct packed {
    logic [FIELD_W-1:0] node_a;
    logic [FIELD_W-1:0] node_b;
  } in_t;

  // Result transfer
  typedef struct packed {
    logic               already_same;
    logic [FIELD_W-1:0] joined_root;
    logic [SIZE_W-1:0]  set_size;
    logic [CNT_W-1:0]   join_count;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_FIND,
    S_COMP,
    S_FIN,
    S_JOIN_ROOT,
    S_JOIN_CHILD
  } state_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic clr_last;
    logic is_root;
    logic start_is_cur;
    logic next_is_root;
    logic phase_b;
    logic same_root;
  } stat_t;

  // Sequencer outputs
  typedef struct packed {
    state_t state;
    logic   busy;
    logic   emit;
  } ctrl_t;

  // Out-of-range node indexes saturate to the last entry
  function automatic idx_t clamp_idx(input logic [FIELD_W-1:0] v);
    if (32'(v) >= 32'(NODES)) begin
      return idx_t'(NODES - 1);
    end
    return idx_t'(v);
  endfunction

endpackage

`default_nettype wire

### rtl/core/ufme_ram.sv
`default_nettype none

module ufme_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/ufme_seq.sv
`default_nettype none

module ufme_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ufme_pkg::stat_t stat,
  output ufme_pkg::ctrl_t      ctrl
);

  ufme_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ufme_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ufme_pkg::S_CLEAR: begin
        if (stat.clr_last) state_nxt = ufme_pkg::S_IDLE;
      end
      ufme_pkg::S_IDLE: begin
        if (stat.start) state_nxt = ufme_pkg::S_LOAD;
      end
      ufme_pkg::S_LOAD: begin
        state_nxt = ufme_pkg::S_FIND;
      end
      ufme_pkg::S_FIND: begin
        if (stat.is_root) begin
          state_nxt = stat.start_is_cur ? ufme_pkg::S_FIN : ufme_pkg::S_COMP;
        end
      end
      ufme_pkg::S_COMP: begin
        if (stat.next_is_root) state_nxt = ufme_pkg::S_FIN;
      end
      ufme_pkg::S_FIN: begin
        if (!stat.phase_b) begin
          state_nxt = ufme_pkg::S_LOAD;
        end else if (stat.same_root) begin
          state_nxt = ufme_pkg::S_IDLE;
        end else begin
          state_nxt = ufme_pkg::S_JOIN_ROOT;
        end
      end
      ufme_pkg::S_JOIN_ROOT: begin
        state_nxt = ufme_pkg::S_JOIN_CHILD;
      end
      ufme_pkg::S_JOIN_CHILD: begin
        state_nxt = ufme_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ufme_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.state = state_r;
    ctrl.busy  = (state_r != ufme_pkg::S_IDLE);
    ctrl.emit  = ((state_r == ufme_pkg::S_FIN) && stat.phase_b && stat.same_root) ||
                 (state_r == ufme_pkg::S_JOIN_CHILD);
  end

endmodule

`default_nettype wire

### rtl/core/union_find_merge_engine.sv
// Disjoint-set join engine, table of parent/size entries in one registered-read RAM.
// Each node of a request is loaded, its path walked to the root and then pointed
// at that root; when the roots differ, the root size and then the child link are
// written. One request in flight, no receiver stall; the result shows for one cycle
// on out_valid, which rises as busy drops, so the next request is taken at the earliest
// at the edge ending that strobe. After reset a clearing pass runs (busy high).
`default_nettype none

module union_find_merge_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire ufme_pkg::in_t in_req,
  output logic               out_valid,
  output ufme_pkg::out_t     out_res
);

  localparam ufme_pkg::entry_t ROOT_MARK = '1;

  ufme_pkg::stat_t  stat;
  ufme_pkg::ctrl_t  ctrl;

  logic                     ram_we;
  ufme_pkg::idx_t           ram_waddr;
  logic [ufme_pkg::ENTRY_W-1:0] ram_wdata;
  ufme_pkg::idx_t           ram_raddr;
  logic [ufme_pkg::ENTRY_W-1:0] ram_rdata;
  ufme_pkg::entry_t         rd_val;
  ufme_pkg::idx_t           rd_idx;

  ufme_pkg::idx_t   a_r, b_r, cur_r, walk_r, root_r, ra_r, clr_r;
  ufme_pkg::idx_t   a_nxt, b_nxt, cur_nxt, walk_nxt, root_nxt, ra_nxt, clr_nxt;
  ufme_pkg::entry_t rootv_r, va_r, rootv_nxt, va_nxt;
  logic             phase_r, phase_nxt;
  logic [ufme_pkg::CNT_W-1:0] joins_r, joins_nxt;
  logic             out_valid_r, out_valid_nxt;
  ufme_pkg::out_t   out_r, out_nxt;

  ufme_pkg::idx_t   start_idx;
  logic             swap;
  ufme_pkg::entry_t sum_v;
  ufme_pkg::entry_t neg_root, neg_va;

  assign rd_val    = ufme_pkg::entry_t'(ram_rdata);
  assign rd_idx    = ram_rdata[ufme_pkg::IDX_W-1:0];
  assign start_idx = phase_r ? b_r : a_r;
  assign swap      = (va_r > rootv_r);
  assign sum_v     = va_r + rootv_r;
  assign neg_root  = -rootv_r;
  assign neg_va    = -va_r;

  // Status toward the sequencer
  always_comb begin
    stat.start        = start;
    stat.clr_last     = (clr_r == ufme_pkg::idx_t'(ufme_pkg::NODES - 1));
    stat.is_root      = rd_val[ufme_pkg::ENTRY_W-1];
    stat.start_is_cur = (start_idx == cur_r);
    stat.next_is_root = (rd_idx == root_r);
    stat.phase_b      = phase_r;
    stat.same_root    = (ra_r == root_r);
  end

  ufme_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  ufme_ram #(
    .WIDTH (ufme_pkg::ENTRY_W),
    .DEPTH (ufme_pkg::NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Table access and datapath updates
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = ROOT_MARK;
    ram_raddr     = start_idx;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    walk_nxt      = walk_r;
    root_nxt      = root_r;
    rootv_nxt     = rootv_r;
    ra_nxt        = ra_r;
    va_nxt        = va_r;
    phase_nxt     = phase_r;
    clr_nxt       = clr_r;
    joins_nxt     = joins_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (ctrl.state)
      ufme_pkg::S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
      end
      ufme_pkg::S_IDLE: begin
        a_nxt     = ufme_pkg::clamp_idx(in_req.node_a);
        b_nxt     = ufme_pkg::clamp_idx(in_req.node_b);
        phase_nxt = 1'b0;
      end
      ufme_pkg::S_LOAD: begin
        ram_raddr = start_idx;
        cur_nxt   = start_idx;
      end
      ufme_pkg::S_FIND: begin
        if (stat.is_root) begin
          root_nxt  = cur_r;
          rootv_nxt = rd_val;
          walk_nxt  = start_idx;
          ram_raddr = start_idx;
        end else begin
          cur_nxt   = rd_idx;
          ram_raddr = rd_idx;
        end
      end
      ufme_pkg::S_COMP: begin
        // point the walked node at its root, move on to its old parent
        ram_we    = 1'b1;
        ram_waddr = walk_r;
        ram_wdata = ufme_pkg::ENTRY_W'(root_r);
        ram_raddr = rd_idx;
        walk_nxt  = rd_idx;
      end
      ufme_pkg::S_FIN: begin
        if (!phase_r) begin
          ra_nxt    = root_r;
          va_nxt    = rootv_r;
          phase_nxt = 1'b1;
        end
      end
      ufme_pkg::S_JOIN_ROOT: begin
        // larger set keeps its root; ties keep node_a's root
        ram_we    = 1'b1;
        ram_waddr = swap ? root_r : ra_r;
        ram_wdata = sum_v;
        ra_nxt    = swap ? root_r : ra_r;
        root_nxt  = swap ? ra_r : root_r;
        va_nxt    = sum_v;
      end
      ufme_pkg::S_JOIN_CHILD: begin
        ram_we    = 1'b1;
        ram_waddr = root_r;
        ram_wdata = ufme_pkg::ENTRY_W'(ra_r);
        joins_nxt = joins_r + 1'b1;
      end
      default: begin
      end
    endcase

    // Result transfer
    if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
      if (ctrl.state == ufme_pkg::S_JOIN_CHILD) begin
        out_nxt.already_same = 1'b0;
        out_nxt.joined_root  = ufme_pkg::FIELD_W'(ra_r);
        out_nxt.set_size     = neg_va[ufme_pkg::SIZE_W-1:0];
        out_nxt.join_count   = joins_r + 1'b1;
      end else begin
        out_nxt.already_same = 1'b1;
        out_nxt.joined_root  = ufme_pkg::FIELD_W'(root_r);
        out_nxt.set_size     = neg_root[ufme_pkg::SIZE_W-1:0];
        out_nxt.join_count   = joins_r;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      joins_r     <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      clr_r       <= clr_nxt;
      joins_r     <= joins_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    cur_r   <= cur_nxt;
    walk_r  <= walk_nxt;
    root_r  <= root_nxt;
    rootv_r <= rootv_nxt;
    ra_r    <= ra_nxt;
    va_r    <= va_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = ctrl.busy;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

### tb/sv/tb_union_find_merge_engine.sv
`timescale 1ns / 1ps

module tb_union_find_merge_engine;

  localparam int STALL_LIMIT = 4096;
  localparam int DRAIN_CYCLES = 64;

  // Disjoint-set predictor plus the queue of results still owed by the engine
  class dsu_scoreboard;
    ufme_pkg::entry_t link_or_size [ufme_pkg::NODES];
    logic [ufme_pkg::CNT_W-1:0] merges;
    ufme_pkg::out_t expected_res[$];
    int errors;
    int checked;
    int largest;

    function new();
      for (int i = 0; i < ufme_pkg::NODES; i++) link_or_size[i] = -1;
      merges = '0;
      errors = 0;
      checked = 0;
      largest = 1;
    endfunction

    // Walk to the root, then point every node on the path straight at it
    function ufme_pkg::idx_t root_of(input ufme_pkg::idx_t node);
      ufme_pkg::idx_t r;
      ufme_pkg::idx_t nxt;
      int guard;
      r = node;
      guard = 0;
      while (link_or_size[r] >= 0 && guard < ufme_pkg::NODES) begin
        r = ufme_pkg::idx_t'(link_or_size[r]);
        guard++;
      end
      guard = 0;
      while (node != r && link_or_size[node] >= 0 && guard < ufme_pkg::NODES) begin
        nxt = ufme_pkg::idx_t'(link_or_size[node]);
        link_or_size[node] = ufme_pkg::entry_t'(r);
        node = nxt;
        guard++;
      end
      return r;
    endfunction

    // Accepted request: update the sets and queue the result it owes
    function void note_request(input ufme_pkg::in_t req);
      ufme_pkg::idx_t ra;
      ufme_pkg::idx_t rb;
      ufme_pkg::idx_t tmp;
      ufme_pkg::entry_t sz;
      ufme_pkg::out_t want;
      ra = root_of(req.node_a >= ufme_pkg::NODES ? ufme_pkg::idx_t'(ufme_pkg::NODES - 1)
                                                 : ufme_pkg::idx_t'(req.node_a));
      rb = root_of(req.node_b >= ufme_pkg::NODES ? ufme_pkg::idx_t'(ufme_pkg::NODES - 1)
                                                 : ufme_pkg::idx_t'(req.node_b));
      want = '0;
      if (ra == rb) begin
        want.already_same = 1'b1;
      end else begin
        // smaller set hangs under larger; tie keeps node_a's root
        if (link_or_size[ra] > link_or_size[rb]) begin
          tmp = ra;
          ra = rb;
          rb = tmp;
        end
        link_or_size[ra] = link_or_size[ra] + link_or_size[rb];
        link_or_size[rb] = ufme_pkg::entry_t'(ra);
        merges = merges + 1'b1;
      end
      sz = -link_or_size[ra];
      want.joined_root = ufme_pkg::FIELD_W'(ra);
      want.set_size = sz[ufme_pkg::SIZE_W-1:0];
      want.join_count = merges;
      if (int'(sz) > largest) largest = int'(sz);
      expected_res = {expected_res, want};
    endfunction

    function void cmp_field(input string name, input int unsigned want,
                            input int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input ufme_pkg::out_t got);
      ufme_pkg::out_t want;
      if (expected_res.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_res.pop_front();
      checked++;
      cmp_field("already_same", want.already_same, got.already_same);
      cmp_field("joined_root", want.joined_root, got.joined_root);
      cmp_field("set_size", want.set_size, got.set_size);
      cmp_field("join_count", want.join_count, got.join_count);
    endfunction

    function int outstanding();
      return expected_res.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  ufme_pkg::in_t  in_req;
  logic out_valid;
  ufme_pkg::out_t out_res;

  dsu_scoreboard sb;
  int sent;
  bit burst_run;
  int stall_cycles;
  int order [ufme_pkg::NODES];

  union_find_merge_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one request at the falling edge, hold it until the engine takes it
  task automatic send_pair(input logic [ufme_pkg::FIELD_W-1:0] a,
                           input logic [ufme_pkg::FIELD_W-1:0] b);
    int gap;
    ufme_pkg::in_t req;
    if (sent % 32 == 0) burst_run = ($urandom_range(0, 3) == 0);
    gap = burst_run ? 0 : $urandom_range(0, 15);
    req.node_a = a;
    req.node_b = b;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(req);
    sent++;
    @(negedge clk);
  endtask

  // Result side: every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_res);
  end

  // Watchdog on cycles without any transfer (covers the clearing pass too)
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("union_find_merge_engine: mismatch");
    $finish;
  end

  initial begin
    int base;
    int a;
    int b;
    int j;
    int tmp;
    sb = new();
    sent = 0;
    burst_run = 1'b0;
    start = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: same node twice, extreme indexes, tie and size ordering
    send_pair(10'd0, 10'd0);
    send_pair(10'd1023, 10'd1023);
    send_pair(10'd0, 10'd1023);
    send_pair(10'd1023, 10'd0);
    send_pair(10'd1, 10'd2);
    send_pair(10'd3, 10'd4);
    send_pair(10'd3, 10'd1);
    send_pair(10'd5, 10'd1);
    send_pair(10'd0, 10'd5);
    send_pair(10'h2AA, 10'h155);
    send_pair(10'h155, 10'h3FF);
    // build a three-level tree, then walk it from a deep leaf
    send_pair(10'd16, 10'd17);
    send_pair(10'd18, 10'd19);
    send_pair(10'd16, 10'd18);
    send_pair(10'd20, 10'd21);
    send_pair(10'd22, 10'd23);
    send_pair(10'd20, 10'd22);
    send_pair(10'd16, 10'd20);
    send_pair(10'd23, 10'd0);
    send_pair(10'd23, 10'd17);
    send_pair(10'd17, 10'd17);
    send_pair(10'd512, 10'd511);

    // Clustered requests in a sliding window: deep trees, many repeat hits
    base = 0;
    for (int k = 0; k < 300; k++) begin
      if (k % 25 == 0) base = $urandom_range(0, ufme_pkg::NODES - 32);
      a = base + $urandom_range(0, 31);
      b = ($urandom_range(0, 9) == 0) ? a : base + $urandom_range(0, 31);
      send_pair(a[ufme_pkg::FIELD_W-1:0], b[ufme_pkg::FIELD_W-1:0]);
    end

    // Scattered requests over the whole table
    for (int k = 0; k < 150; k++) begin
      a = $urandom_range(0, ufme_pkg::NODES - 1);
      b = $urandom_range(0, ufme_pkg::NODES - 1);
      send_pair(a[ufme_pkg::FIELD_W-1:0], b[ufme_pkg::FIELD_W-1:0]);
    end

    // Connecting sweep in shuffled order: ends with every node in one set
    for (int i = 0; i < ufme_pkg::NODES; i++) order[i] = i;
    for (int i = ufme_pkg::NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int k = 1; k < ufme_pkg::NODES; k++) begin
      a = order[k];
      b = order[$urandom_range(0, k - 1)];
      if ($urandom_range(0, 1) == 1) begin
        send_pair(a[ufme_pkg::FIELD_W-1:0], b[ufme_pkg::FIELD_W-1:0]);
      end else begin
        send_pair(b[ufme_pkg::FIELD_W-1:0], a[ufme_pkg::FIELD_W-1:0]);
      end
    end

    // Everything joined: only repeat hits on the full set remain
    for (int k = 0; k < 50; k++) begin
      a = $urandom_range(0, ufme_pkg::NODES - 1);
      b = $urandom_range(0, ufme_pkg::NODES - 1);
      send_pair(a[ufme_pkg::FIELD_W-1:0], b[ufme_pkg::FIELD_W-1:0]);
    end
    start <= 1'b0;

    // Drain the outstanding results, then watch for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d join requests, checked %0d results.", sent, sb.checked);
    $display("Joins done: %0d, largest set seen: %0d nodes.", sb.merges, sb.largest);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("union_find_merge_engine: match");
    end else begin
      $display("union_find_merge_engine: mismatch");
    end
    $finish;
  end

endmodule
